// File: hw/rtl/isfp_pkg.sv
// Shared types, constants and the command decoder of the IMU serial frame parser.
package isfp_pkg;

  localparam int unsigned FrameLength  = 11;
  // Position of the checksum byte within the frame.
  localparam int unsigned CheckPos     = FrameLength - 1;
  // Bytes from the command up to the last payload byte (command and six word bytes).
  localparam int unsigned PayloadBytes = 7;
  localparam int unsigned PosWidth     = $clog2(FrameLength);

  localparam logic [7:0] HeaderByte = 8'h55;
  localparam logic [7:0] CmdAccel   = 8'h51;
  localparam logic [7:0] CmdRate    = 8'h52;
  localparam logic [7:0] CmdAngle   = 8'h53;
  localparam logic [7:0] CmdTemp    = 8'h54;

  typedef enum logic [2:0] {
    KIND_ACCEL = 3'd0,
    KIND_RATE  = 3'd1,
    KIND_ANGLE = 3'd2,
    KIND_TEMP  = 3'd3,
    KIND_OTHER = 3'd4
  } frame_kind_t;

  // One checked frame as it waits between the assembler and the output stage.
  typedef struct packed {
    logic [7:0]         command_code;
    logic signed [15:0] word_x;
    logic signed [15:0] word_y;
    logic signed [15:0] word_z;
  } frame_rec_t;

  function automatic frame_kind_t kind_of(input logic [7:0] cmd);
    frame_kind_t kind;
    unique case (cmd)
      CmdAccel: kind = KIND_ACCEL;
      CmdRate:  kind = KIND_RATE;
      CmdAngle: kind = KIND_ANGLE;
      CmdTemp:  kind = KIND_TEMP;
      default:  kind = KIND_OTHER;
    endcase
    return kind;
  endfunction

endpackage

// File: hw/rtl/isfp_byte_if.sv
// Valid/ready channel carrying one received serial byte per beat.
interface isfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: hw/rtl/isfp_frame_if.sv
// Valid/ready channel carrying one decoded sensor frame per beat.
interface isfp_frame_if;
  logic               valid;
  logic               ready;
  logic [2:0]         frame_kind;
  logic [7:0]         command_code;
  logic signed [15:0] word_x;
  logic signed [15:0] word_y;
  logic signed [15:0] word_z;

  modport source (output valid, output frame_kind, output command_code,
                  output word_x, output word_y, output word_z, input ready);
  modport sink   (input valid, input frame_kind, input command_code,
                  input word_x, input word_y, input word_z, output ready);
endinterface

// File: hw/rtl/isfp_front.sv
// Byte front end: header hunt, frame assembly and running checksum.
module isfp_front (
  input  logic                clk,
  input  logic                rst,
  isfp_byte_if.sink           rx,
  input  logic                q_full,
  output logic                push,
  output isfp_pkg::frame_rec_t push_rec
);

  logic                             collecting;
  logic [isfp_pkg::PosWidth-1:0]    byte_position;
  logic [7:0]                       running_sum;
  logic [7:0]                       shift_line [isfp_pkg::PayloadBytes];

  logic accept;
  logic at_check;
  logic in_payload;

  assign at_check   = collecting &&
                      (byte_position == isfp_pkg::PosWidth'(isfp_pkg::CheckPos));
  assign in_payload = collecting &&
                      (byte_position <= isfp_pkg::PosWidth'(isfp_pkg::PayloadBytes));
  // Only the checksum beat needs room in the queue.
  assign rx.ready   = !(at_check && q_full);
  assign accept     = rx.valid && rx.ready;
  assign push       = accept && at_check && (rx.rx_byte == running_sum);

  // The newest byte sits at index 0, so the command byte ends at the far end.
  assign push_rec.command_code = shift_line[6];
  assign push_rec.word_x       = {shift_line[4], shift_line[5]};
  assign push_rec.word_y       = {shift_line[2], shift_line[3]};
  assign push_rec.word_z       = {shift_line[0], shift_line[1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      collecting    <= 1'b0;
      byte_position <= '0;
      running_sum   <= '0;
    end else if (accept) begin
      if (!collecting) begin
        if (rx.rx_byte == isfp_pkg::HeaderByte) begin
          collecting    <= 1'b1;
          byte_position <= isfp_pkg::PosWidth'(1);
          running_sum   <= rx.rx_byte;
        end
      end else if (!at_check) begin
        byte_position <= byte_position + isfp_pkg::PosWidth'(1);
        running_sum   <= running_sum + rx.rx_byte;
      end else begin
        collecting    <= 1'b0;
        byte_position <= '0;
        running_sum   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_payload) begin
      shift_line[0] <= rx.rx_byte;
      for (int i = 1; i < isfp_pkg::PayloadBytes; i++) begin
        shift_line[i] <= shift_line[i-1];
      end
    end
  end

endmodule

// File: hw/rtl/isfp_queue.sv
// Short first-in first-out queue of checked frames between front and back.
module isfp_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  isfp_pkg::frame_rec_t push_rec,
  input  logic                 pop,
  output logic                 full,
  output logic                 not_empty,
  output isfp_pkg::frame_rec_t head_rec
);

  localparam int unsigned PtrW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CountW = $clog2(DEPTH + 1);

  isfp_pkg::frame_rec_t entries [DEPTH];
  logic [PtrW-1:0]      wr_ptr;
  logic [PtrW-1:0]      rd_ptr;
  logic [CountW-1:0]    count;
  logic                 do_push;
  logic                 do_pop;

  assign full      = (count == CountW'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_rec  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CountW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CountW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

endmodule

// File: hw/rtl/isfp_back.sv
// Back end: classifies the command of a queued frame and holds the result register.
module isfp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_not_empty,
  input  isfp_pkg::frame_rec_t head_rec,
  output logic                 pop,
  isfp_frame_if.source         frame
);

  logic                  out_valid;
  isfp_pkg::frame_kind_t out_kind;
  isfp_pkg::frame_rec_t  out_rec;

  // Refill the result register whenever it is empty or being taken this cycle.
  assign pop = q_not_empty && (!out_valid || frame.ready);

  assign frame.valid        = out_valid;
  assign frame.frame_kind   = out_kind;
  assign frame.command_code = out_rec.command_code;
  assign frame.word_x       = out_rec.word_x;
  assign frame.word_y       = out_rec.word_y;
  assign frame.word_z       = out_rec.word_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (frame.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_kind <= isfp_pkg::kind_of(head_rec.command_code);
      out_rec  <= head_rec;
    end
  end

endmodule

// File: hw/rtl/imu_serial_frame_parser_top.sv
// Top level of the IMU serial frame parser.
// Usage: the rx channel takes one received serial byte per beat. While hunting,
// bytes other than the 0x55 header are dropped; a header opens an 11-byte frame
// whose last byte must equal the 8-bit sum of the ten before it. A good frame
// gives one beat on the frame channel: the kind code, the command byte and the
// three little-endian signed words, raw. A bad frame gives nothing and the
// parser hunts again from the next byte.
// Throughput: one byte per cycle, but a checksum beat waits while the queue is
// full; the output stage can hand on one frame per cycle while the receiver
// takes them. A good frame is written into the frame queue at its checksum
// beat and then moved on into the result register that drives the frame beat.
// Reset (synchronous, rst high) returns the parser to hunting and empties the
// queue and result register.
// When the receiver stalls, finished frames wait in the QUEUE_DEPTH-entry queue
// and in the result register; bytes keep flowing, and only a checksum beat is
// held back while the queue is full.
module imu_serial_frame_parser_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  isfp_byte_if.sink     rx,
  isfp_frame_if.source  frame
);

  logic                 q_full;
  logic                 q_not_empty;
  logic                 push;
  logic                 pop;
  isfp_pkg::frame_rec_t push_rec;
  isfp_pkg::frame_rec_t head_rec;

  isfp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx),
    .q_full   (q_full),
    .push     (push),
    .push_rec (push_rec)
  );

  isfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_rec  (push_rec),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_rec  (head_rec)
  );

  isfp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .head_rec    (head_rec),
    .pop         (pop),
    .frame       (frame)
  );

endmodule

// File: dv/tb_top.sv
// Self-checking testbench of the IMU serial frame parser: byte stimulus, frame prediction and checks.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned ByteCount   = 1250;

  typedef struct {
    isfp_pkg::frame_kind_t kind;
    logic [7:0]            command_code;
    logic signed [15:0]    word_x;
    logic signed [15:0]    word_y;
    logic signed [15:0]    word_z;
  } frame_expect_t;

  class frame_checker;
    bit            collecting;
    int unsigned   position;
    logic [7:0]    checksum;
    logic [7:0]    frame_buf [isfp_pkg::CheckPos];
    frame_expect_t frames_due [$];
    int unsigned   mismatches;
    int unsigned   frames_checked;
    int unsigned   kind_count [5];

    function new();
      collecting     = 1'b0;
      position       = 0;
      checksum       = 8'h00;
      mismatches     = 0;
      frames_checked = 0;
      foreach (kind_count[i]) kind_count[i] = 0;
    endfunction

    function isfp_pkg::frame_kind_t command_kind(logic [7:0] cmd);
      case (cmd)
        isfp_pkg::CmdAccel: return isfp_pkg::KIND_ACCEL;
        isfp_pkg::CmdRate:  return isfp_pkg::KIND_RATE;
        isfp_pkg::CmdAngle: return isfp_pkg::KIND_ANGLE;
        isfp_pkg::CmdTemp:  return isfp_pkg::KIND_TEMP;
        default:            return isfp_pkg::KIND_OTHER;
      endcase
    endfunction

    // Notes one accepted byte; returns 1 when the byte was taken into a frame.
    function bit take_byte(logic [7:0] b);
      frame_expect_t e;
      if (!collecting) begin
        if (b != isfp_pkg::HeaderByte) return 1'b0;
        frame_buf[0] = b;
        checksum     = b;
        position     = 1;
        collecting   = 1'b1;
        return 1'b1;
      end
      if (position < isfp_pkg::CheckPos) begin
        frame_buf[position] = b;
        checksum            = checksum + b;
        position++;
        return 1'b1;
      end
      collecting = 1'b0;
      position   = 0;
      if (b == checksum) begin
        e.command_code = frame_buf[1];
        e.kind         = command_kind(frame_buf[1]);
        e.word_x       = {frame_buf[3], frame_buf[2]};
        e.word_y       = {frame_buf[5], frame_buf[4]};
        e.word_z       = {frame_buf[7], frame_buf[6]};
        frames_due.push_back(e);
      end
      checksum = 8'h00;
      return 1'b1;
    endfunction

    task report(string msg);
      mismatches++;
      $display("%0t ns: mismatch: %s", $realtime, msg);
    endtask

    task check_frame(logic [2:0] kind, logic [7:0] cmd,
                     logic [15:0] x, logic [15:0] y, logic [15:0] z);
      frame_expect_t e;
      if (frames_due.size() == 0) begin
        report($sformatf("frame with command %02h while none was due", cmd));
        return;
      end
      e = frames_due.pop_front();
      frames_checked++;
      kind_count[int'(e.kind)]++;
      if (kind !== e.kind)
        report($sformatf("frame_kind %0d, wanted %0d", kind, e.kind));
      if (cmd !== e.command_code)
        report($sformatf("command_code %02h, wanted %02h", cmd, e.command_code));
      if (x !== e.word_x)
        report($sformatf("word_x %04h, wanted %04h", x, e.word_x));
      if (y !== e.word_y)
        report($sformatf("word_y %04h, wanted %04h", y, e.word_y));
      if (z !== e.word_z)
        report($sformatf("word_z %04h, wanted %04h", z, e.word_z));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  isfp_byte_if  rx_if ();
  isfp_frame_if frame_if ();

  imu_serial_frame_parser_top uut (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx_if),
    .frame (frame_if)
  );

  frame_checker frame_chk = new();

  int unsigned burst_left   = 0;
  int unsigned bytes_sent   = 0;
  int unsigned bytes_framed = 0;
  int unsigned bad_frames   = 0;
  int unsigned quiet_cycles = 0;
  bit          hold_request = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic idle_gap(int unsigned n);
    if (n == 0) return;
    rx_if.valid = 1'b0;
    repeat (n) begin
      rx_if.rx_byte = 8'($urandom);
      @(negedge clk);
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_byte(logic [7:0] b);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0)
        idle_gap(($urandom_range(0, 7) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 4));
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    rx_if.valid   = 1'b1;
    rx_if.rx_byte = b;
    do @(posedge clk); while (!rx_if.ready);
    bytes_sent++;
    if (frame_chk.take_byte(b)) bytes_framed++;
    @(negedge clk);
  endtask

  task automatic send_frame(logic [7:0] cmd, logic [15:0] x, logic [15:0] y,
                            logic [15:0] z, logic [15:0] tail, logic [7:0] flip);
    logic [7:0] f [isfp_pkg::FrameLength];
    logic [7:0] sum;
    f[0] = isfp_pkg::HeaderByte;
    f[1] = cmd;
    f[2] = x[7:0];
    f[3] = x[15:8];
    f[4] = y[7:0];
    f[5] = y[15:8];
    f[6] = z[7:0];
    f[7] = z[15:8];
    f[8] = tail[7:0];
    f[9] = tail[15:8];
    sum  = 8'h00;
    for (int i = 0; i < isfp_pkg::CheckPos; i++) sum = sum + f[i];
    f[isfp_pkg::CheckPos] = sum ^ flip;
    if (flip != 8'h00) bad_frames++;
    for (int i = 0; i < isfp_pkg::FrameLength; i++) send_byte(f[i]);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_command();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) return isfp_pkg::CmdAccel + 8'($urandom_range(0, 3));
    if (r == 7) return isfp_pkg::HeaderByte;
    return 8'($urandom);
  endfunction

  initial begin : receiver
    int unsigned mode;
    int unsigned mode_left;
    mode      = 0;
    mode_left = 0;
    frame_if.ready = 1'b0;
    forever begin
      if (hold_request) begin
        hold_request   = 1'b0;
        frame_if.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      case (mode)
        0:       frame_if.ready = 1'b1;
        1:       frame_if.ready = 1'($urandom_range(0, 1));
        default: frame_if.ready = ($urandom_range(0, 3) == 0);
      endcase
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && frame_if.valid && frame_if.ready)
      frame_chk.check_frame(frame_if.frame_kind, frame_if.command_code,
                            frame_if.word_x, frame_if.word_y, frame_if.word_z);
  end

  always @(posedge clk) begin
    if (rst || (rx_if.valid && rx_if.ready) || (frame_if.valid && frame_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("Watchdog: no beat on either channel for %0d cycles.", StallLimit);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned pick;
    bit          pressure_done;
    pressure_done = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = 8'h00;
    rst           = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Bytes met while hunting are dropped.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(isfp_pkg::CmdTemp);
    send_byte(8'h56);
    send_frame(isfp_pkg::CmdAccel, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 8'h00);
    send_frame(isfp_pkg::CmdRate, 16'hFFFF, 16'h0001, 16'h8000, 16'h0000, 8'h00);
    // Header bytes in the payload are plain data.
    send_frame(isfp_pkg::CmdAngle, 16'h5555, 16'h0055, 16'h5500, 16'h5555, 8'h00);
    send_frame(isfp_pkg::CmdTemp, 16'd2500, 16'hA5A5, 16'h5A5A, 16'h1234, 8'h00);
    send_frame(8'hFF, 16'h0102, 16'hFEFD, 16'h8001, 16'h00FF, 8'h00);
    // Bad checksum that happens to be a header byte: it must not open a frame.
    send_frame(isfp_pkg::CmdAccel, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'hF3);
    send_frame(isfp_pkg::HeaderByte, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 8'h00);
    send_frame(8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h80);

    while (bytes_sent < ByteCount) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_frame(pick_command(), pick_word(), pick_word(), pick_word(),
                   16'($urandom), 8'h00);
      end else if (pick < 82) begin
        send_frame(pick_command(), pick_word(), pick_word(), pick_word(),
                   16'($urandom), 8'($urandom_range(1, 255)));
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end else begin
        // A frame cut short, so the next header lands inside it.
        send_byte(isfp_pkg::HeaderByte);
        repeat ($urandom_range(1, 9)) send_byte(8'($urandom));
      end
      if (!pressure_done && bytes_framed > 400) begin
        hold_request  = 1'b1;
        pressure_done = 1'b1;
      end
    end

    rx_if.valid = 1'b0;
    while (frame_chk.frames_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Run covered %0d bytes, %0d inside frames, %0d corrupted frames, %0d frames checked.",
             bytes_sent, bytes_framed, bad_frames, frame_chk.frames_checked);
    $display("Kinds seen: accel %0d, rate %0d, angle %0d, temp %0d, other %0d; one long hold-off.",
             frame_chk.kind_count[0], frame_chk.kind_count[1], frame_chk.kind_count[2],
             frame_chk.kind_count[3], frame_chk.kind_count[4]);
    if (frame_chk.mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
